/* design/square_matrix_multiply_accumulate_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply-accumulate core
// Concurrent checks clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication
`define SMMA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SMMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/smma_pkg.sv */
// ----------------------------------------------------------------------------
// smma_pkg
// Shared constants, types and address helper of the matrix MAC core.
// ----------------------------------------------------------------------------
package smma_pkg;

    localparam int DIM   = 16;                 // matrix side, 2 .. 16
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DIM);

    localparam logic [1:0] CMD_WRITE_LEFT  = 2'd0;
    localparam logic [1:0] CMD_WRITE_RIGHT = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY    = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // one MAC step travelling down the pipeline
    typedef struct packed {
        logic          valid;
        logic          first;   // k == 0: seed accumulator from product store
        logic          last;    // k == DIM-1: write back
        logic [AW-1:0] addr;    // product element i*DIM+j
    } tag_t;

    typedef struct packed {
        tag_t          tag;
        logic [AW-1:0] lft_addr;
        logic [AW-1:0] rgt_addr;
    } issue_t;

    typedef struct packed {
        logic          clr_we;
        logic [AW-1:0] clr_addr;
        logic          load_rd;
        logic          load_done;
    } ctl_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } wr_t;

    function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] r,
                                                input logic [AW-1:0] c);
        return r * AW'(DIM) + c;
    endfunction

endpackage

/* design/square_matrix_multiply_accumulate_core.sv */
// ----------------------------------------------------------------------------
// square_matrix_multiply_accumulate_core
// DIM x DIM matrix multiply-accumulate on one shared 32-bit MAC unit.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser carries the command (write left, write right,
// multiply, read product); s_tdata carries row, col and the write value.
// Output stream (m_*): m_tuser is the kind (0 data, 1 multiply done),
// m_tdata the product element, or zero for done.
// Writes give no transaction. A read registers its element from the product
// store, then loads it into the output register once that is free. A multiply
// runs DIM^3 MAC steps, one per cycle through the shared multiplier and adder,
// waits for the pipeline to drain and then gives one done transaction.
// s_tready is high only while the sequencer is idle; one item at a time.
// After reset the product store is cleared at one element per cycle, so
// s_tready stays low until every element has been cleared.
// A stalled receiver holds the result in the output register; any command
// can still be taken meanwhile; a read or done result waits for the slot to free.
// Out-of-range reads return zero; out-of-range writes are dropped.
// ----------------------------------------------------------------------------
`include "square_matrix_multiply_accumulate_core_macros.svh"

module square_matrix_multiply_accumulate_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // row[3:0], col[7:4], value[39:8]
    input  logic [1:0]  s_tuser,    // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // data[31:0]
    output logic        m_tuser     // kind[0]
);

    logic [31:0]              left_mem  [smma_pkg::DEPTH];
    logic [31:0]              right_mem [smma_pkg::DEPTH];
    logic [31:0]              prd_mem   [smma_pkg::DEPTH];

    logic [3:0]               row;
    logic [3:0]               col;
    logic [31:0]              value;
    logic                     accept;
    logic                     in_range;
    logic [smma_pkg::AW-1:0]  cmd_addr;

    smma_pkg::issue_t         issue;
    smma_pkg::ctl_t           ctl;
    smma_pkg::wr_t            mac_wr;
    logic                     mac_busy;
    logic                     pipe_busy;

    logic [31:0]              lft_q, rgt_q, prd_q;
    logic                     s1_valid_reg;
    smma_pkg::tag_t           s1_reg;
    smma_pkg::tag_t           s1_tag;
    logic                     rd_zero_reg;

    logic                     prd_re;
    logic [smma_pkg::AW-1:0]  prd_raddr;
    logic                     prd_we;
    logic [smma_pkg::AW-1:0]  prd_waddr;
    logic [31:0]              prd_wdata;

    logic                     out_valid_reg;
    logic                     out_kind_reg;
    logic [31:0]              out_data_reg;
    logic                     out_free;

    assign row      = s_tdata[3:0];
    assign col      = s_tdata[7:4];
    assign value    = s_tdata[39:8];
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(row) < 32'(smma_pkg::DIM)) && (32'(col) < 32'(smma_pkg::DIM));
    assign cmd_addr = smma_pkg::elem_addr(smma_pkg::AW'(row), smma_pkg::AW'(col));
    assign out_free = !out_valid_reg || m_tready;

    smma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .command   (s_tuser),
        .out_free  (out_free),
        .pipe_busy (pipe_busy),
        .s_tready  (s_tready),
        .issue     (issue),
        .ctl       (ctl)
    );

    // operand stores
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == smma_pkg::CMD_WRITE_LEFT && in_range)
        begin
            left_mem[cmd_addr] <= value;
        end
        if (issue.tag.valid)
        begin
            lft_q <= left_mem[issue.lft_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == smma_pkg::CMD_WRITE_RIGHT && in_range)
        begin
            right_mem[cmd_addr] <= value;
        end
        if (issue.tag.valid)
        begin
            rgt_q <= right_mem[issue.rgt_addr];
        end
    end

    // product store: one read port shared by the MAC seed and read commands
    assign prd_re    = issue.tag.valid || (accept && s_tuser == smma_pkg::CMD_READ);
    assign prd_raddr = issue.tag.valid ? issue.tag.addr : cmd_addr;
    assign prd_we    = ctl.clr_we || mac_wr.en;
    assign prd_waddr = ctl.clr_we ? ctl.clr_addr : mac_wr.addr;
    assign prd_wdata = ctl.clr_we ? 32'd0 : mac_wr.data;

    always_ff @(posedge clk)
    begin
        if (prd_we)
        begin
            prd_mem[prd_waddr] <= prd_wdata;
        end
        if (prd_re)
        begin
            prd_q <= prd_mem[prd_raddr];
        end
    end

    // step tag aligned with the registered memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= issue.tag;
        if (accept && s_tuser == smma_pkg::CMD_READ)
        begin
            rd_zero_reg <= !in_range;
        end
    end

    always_comb
    begin
        s1_tag       = s1_reg;
        s1_tag.valid = s1_valid_reg;
    end

    smma_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1_tag),
        .lft   (lft_q),
        .rgt   (rgt_q),
        .init  (prd_q),
        .wr    (mac_wr),
        .busy  (mac_busy)
    );

    assign pipe_busy = s1_valid_reg || mac_busy;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_rd || ctl.load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_rd)
        begin
            out_kind_reg <= smma_pkg::KIND_DATA;
            out_data_reg <= rd_zero_reg ? 32'd0 : prd_q;
        end
        else if (ctl.load_done)
        begin
            out_kind_reg <= smma_pkg::KIND_DONE;
            out_data_reg <= 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    `SMMA_ASSERT_NEXT(a_mul_blocks, accept && s_tuser == smma_pkg::CMD_MULTIPLY, !s_tready, "multiply did not block input")
    `SMMA_ASSERT_SAME(a_idle_quiet, s_tready, !pipe_busy && !ctl.clr_we, "MAC pipeline active while idle")
    `SMMA_ASSERT_SAME(a_wr_excl, mac_wr.en, !ctl.clr_we, "clear and MAC write collide")

endmodule

/* design/smma_mac.sv */
// ----------------------------------------------------------------------------
// smma_mac
// Shared multiply-accumulate unit: registered 32x32 multiply, then add.
// ----------------------------------------------------------------------------
module smma_mac
(
    input  logic                clk,
    input  logic                rst_n,
    input  smma_pkg::tag_t      s1,
    input  logic [31:0]         lft,
    input  logic [31:0]         rgt,
    input  logic [31:0]         init,
    output smma_pkg::wr_t       wr,
    output logic                busy
);

    logic                s2_valid_reg;
    smma_pkg::tag_t      s2_reg;
    logic [31:0]         mul_reg;
    logic [31:0]         init_reg;
    logic [31:0]         acc_reg;
    logic [31:0]         acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1.valid;
        end
    end

    // low 32 bits of the product: wraps like the accumulate
    always_ff @(posedge clk)
    begin
        s2_reg   <= s1;
        mul_reg  <= lft * rgt;
        init_reg <= init;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_next = (s2_reg.first ? init_reg : acc_reg) + mul_reg;

    assign wr.en   = s2_valid_reg && s2_reg.last;
    assign wr.addr = s2_reg.addr;
    assign wr.data = acc_next;
    assign busy    = s2_valid_reg;

endmodule

/* design/smma_ctrl.sv */
// ----------------------------------------------------------------------------
// smma_ctrl
// Sequencer: clear pass, command dispatch and i/j/k loop of the multiply.
// ----------------------------------------------------------------------------
module smma_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic [1:0]            command,
    input  logic                  out_free,
    input  logic                  pipe_busy,
    output logic                  s_tready,
    output smma_pkg::issue_t      issue,
    output smma_pkg::ctl_t        ctl
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [smma_pkg::IW-1:0] IMAX = smma_pkg::IW'(smma_pkg::DIM - 1);
    localparam logic [smma_pkg::AW-1:0] AMAX = smma_pkg::AW'(smma_pkg::DEPTH - 1);

    logic [2:0]                  state_reg, state_next;
    logic [smma_pkg::IW-1:0]     i_reg, i_next;
    logic [smma_pkg::IW-1:0]     j_reg, j_next;
    logic [smma_pkg::IW-1:0]     k_reg, k_next;
    logic [smma_pkg::AW-1:0]     clr_reg, clr_next;
    logic                        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;

        issue.tag.valid = 1'b0;
        issue.tag.first = (k_reg == '0);
        issue.tag.last  = (k_reg == IMAX);
        issue.tag.addr  = smma_pkg::elem_addr(smma_pkg::AW'(i_reg), smma_pkg::AW'(j_reg));
        issue.lft_addr  = smma_pkg::elem_addr(smma_pkg::AW'(i_reg), smma_pkg::AW'(k_reg));
        issue.rgt_addr  = smma_pkg::elem_addr(smma_pkg::AW'(k_reg), smma_pkg::AW'(j_reg));

        ctl.clr_we    = 1'b0;
        ctl.clr_addr  = clr_reg;
        ctl.load_rd   = 1'b0;
        ctl.load_done = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == AMAX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && command == smma_pkg::CMD_MULTIPLY)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
                else if (accept && command == smma_pkg::CMD_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    ctl.load_rd = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                issue.tag.valid = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == IMAX)
                begin
                    k_next = '0;
                    j_next = j_reg + 1'b1;
                    if (j_reg == IMAX)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                        if (i_reg == IMAX)
                        begin
                            i_next     = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.load_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
